// ===== sv/normalization_cubemap_texel_unit_assert.svh =====
// Assertion macros used by the checker file ncm_chk.sv.
`ifndef NORMALIZATION_CUBEMAP_TEXEL_UNIT_ASSERT_SVH
`define NORMALIZATION_CUBEMAP_TEXEL_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define NCM_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error("ncm assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define NCM_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error("ncm assertion failed");

`endif

// ===== sv/ncm_pkg.sv =====
`default_nettype none
package ncm_pkg;

  localparam int MAX_FACE_SIZE = 256;
  localparam int FACE_W  = 3;
  localparam int COORD_W = 8;
  localparam int SIZE_W  = 9;
  localparam int INT_W   = 9;
  localparam int BYTE_W  = 8;
  localparam int VEC_W   = 11;
  localparam int MAG_W   = 10;
  localparam int K_W     = 16;
  localparam int PROD_W  = 26;
  localparam int M_W     = 20;
  localparam int FRAC_W  = 16;
  localparam int ACC_W   = 60;
  localparam int N_W     = 10;
  localparam int NUM_CELLS = 10;
  localparam int STEP_W  = 4;
  localparam int LANES   = 4;
  localparam int COLORS  = 3;

  localparam int LANE_ALPHA = 0;
  localparam int LANE_RED   = 1;
  localparam int LANE_GREEN = 2;
  localparam int LANE_BLUE  = 3;

  localparam logic [INT_W-1:0] INTENSITY_RESET = 9'd256;
  localparam logic [BYTE_W-1:0] BYTE_MID = 8'd128;
  localparam logic [BYTE_W-1:0] BYTE_MAX = 8'd255;

  typedef enum logic [FACE_W-1:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
    logic signed [VEC_W-1:0] vz;
    logic [K_W-1:0]          k;
  } vec_t;

  typedef struct packed {
    logic [LANES-1:0][PROD_W-1:0] prod;
    logic [COLORS-1:0][M_W-1:0]   sq;
    logic [COLORS-1:0]            neg;
  } prod_t;

  typedef struct packed {
    logic [ACC_W-1:0] rem;
    logic [ACC_W-1:0] p;
    logic [N_W-1:0]   n;
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0]  lane;
    logic [ACC_W-1:0]   mq;
    logic [COLORS-1:0]  neg;
    logic               mzero;
  } root_t;

endpackage
`default_nettype wire

// ===== sv/ncm_ifs.sv =====
`default_nettype none
interface ncm_req_if;
  logic                       valid;
  logic                       ready;
  logic [ncm_pkg::FACE_W-1:0]  face;
  logic [ncm_pkg::COORD_W-1:0] texel_x;
  logic [ncm_pkg::COORD_W-1:0] texel_y;
  logic [ncm_pkg::SIZE_W-1:0]  level_size;
  modport source (output valid, face, texel_x, texel_y, level_size, input ready);
  modport sink (input valid, face, texel_x, texel_y, level_size, output ready);
endinterface

interface ncm_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [ncm_pkg::BYTE_W-1:0] alpha_byte;
  logic [ncm_pkg::BYTE_W-1:0] red_byte;
  logic [ncm_pkg::BYTE_W-1:0] green_byte;
  logic [ncm_pkg::BYTE_W-1:0] blue_byte;
  modport source (output valid, alpha_byte, red_byte, green_byte, blue_byte, input ready);
  modport sink (input valid, alpha_byte, red_byte, green_byte, blue_byte, output ready);
endinterface

interface ncm_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [ncm_pkg::INT_W-1:0] intensity_q8;
  modport source (output valid, intensity_q8, input ready);
  modport sink (input valid, intensity_q8, output ready);
endinterface
`default_nettype wire

// ===== sv/normalization_cubemap_texel_unit.sv =====
// Channel | Dir | Payload                                          | Transfer
// req     | in  | face, texel_x, texel_y, level_size               | valid & ready
// rsp     | out | alpha_byte, red_byte, green_byte, blue_byte     | valid & ready
// cfg     | in  | intensity_q8                                     | valid & ready
// One texel per cycle sustained while rsp is not stalled.
// The path from req to rsp is three front stages (decode, products, squares) plus one
// cell per result bit of the normalizing root (ten) plus the output register.
// Each stage stalls only when full and its successor is stalled, so bubbles close.
// Reset clears all valid flags and sets intensity_q8 to 256; cfg is always ready.
`default_nettype none
module normalization_cubemap_texel_unit (
  input wire logic  clk,
  input wire logic  rst,
  ncm_req_if.sink   req,
  ncm_rsp_if.source rsp,
  ncm_cfg_if.sink   cfg
);
  import ncm_pkg::*;

  logic [INT_W-1:0] intensity;
  logic  cv [NUM_CELLS+1];
  logic  cr [NUM_CELLS+1];
  root_t cd [NUM_CELLS+1];
  logic  out_en;
  root_t fin;
  logic [N_W-1:0] n_a;
  logic [LANES-1:0][BYTE_W-1:0] bytes_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      intensity <= INTENSITY_RESET;
    end else if (cfg.valid) begin
      intensity <= cfg.intensity_q8;
    end
  end

  ncm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_ready   (req.ready),
    .face       (req.face),
    .texel_x    (req.texel_x),
    .texel_y    (req.texel_y),
    .level_size (req.level_size),
    .intensity  (intensity),
    .out_valid  (cv[0]),
    .out_ready  (cr[0]),
    .out_data   (cd[0])
  );

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    ncm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .step      (STEP_W'(NUM_CELLS - 1 - g)),
      .in_valid  (cv[g]),
      .in_ready  (cr[g]),
      .in_data   (cd[g]),
      .out_valid (cv[g+1]),
      .out_ready (cr[g+1]),
      .out_data  (cd[g+1])
    );
  end

  assign out_en = !rsp.valid || rsp.ready;
  assign cr[NUM_CELLS] = out_en;
  assign fin = cd[NUM_CELLS];

  always_comb begin
    n_a = fin.lane[LANE_ALPHA].n;
    if (fin.mzero) begin
      bytes_next[LANE_ALPHA] = '0;
    end else begin
      bytes_next[LANE_ALPHA] = (n_a > N_W'(BYTE_MAX)) ? BYTE_MAX : n_a[BYTE_W-1:0];
    end
    for (int i = 1; i < LANES; i++) begin
      if (fin.mzero) begin
        bytes_next[i] = BYTE_MID;
      end else if (fin.neg[i-1]) begin
        bytes_next[i] = BYTE_MID - fin.lane[i].n[BYTE_W-1:0];
      end else begin
        bytes_next[i] = BYTE_MID + fin.lane[i].n[BYTE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_en) begin
      rsp.valid <= cv[NUM_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && cv[NUM_CELLS]) begin
      rsp.alpha_byte <= bytes_next[LANE_ALPHA];
      rsp.red_byte   <= bytes_next[LANE_RED];
      rsp.green_byte <= bytes_next[LANE_GREEN];
      rsp.blue_byte  <= bytes_next[LANE_BLUE];
    end
  end
endmodule
`default_nettype wire

// ===== sv/ncm_front.sv =====
`default_nettype none
module ncm_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [ncm_pkg::FACE_W-1:0]  face,
  input  wire logic [ncm_pkg::COORD_W-1:0] texel_x,
  input  wire logic [ncm_pkg::COORD_W-1:0] texel_y,
  input  wire logic [ncm_pkg::SIZE_W-1:0]  level_size,
  input  wire logic [ncm_pkg::INT_W-1:0]   intensity,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output ncm_pkg::root_t                   out_data
);
  import ncm_pkg::*;

  logic v1, v2, v3;
  logic en1, en2, en3;
  vec_t  s1, s1_next;
  prod_t s2, s2_next;
  root_t s3_next;

  logic [SIZE_W-1:0] s_sat;
  logic signed [VEC_W-1:0] u, v;
  logic [LANES-1:0][MAG_W-1:0] mag;
  logic [M_W-1:0] m_sum;

  assign en3 = !v3 || out_ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;
  assign out_valid = v3;

  always_comb begin
    s_sat = (level_size > SIZE_W'(MAX_FACE_SIZE)) ? SIZE_W'(MAX_FACE_SIZE) : level_size;
    u = $signed({2'b00, texel_x, 1'b1}) - $signed({2'b00, s_sat});
    v = $signed({2'b00, texel_y, 1'b1}) - $signed({2'b00, s_sat});
    s1_next.k = {intensity, 7'd0} - {7'd0, intensity};
    unique case (face)
      FACE_POS_X: begin
        s1_next.vx = $signed({2'b00, s_sat});
        s1_next.vy = -v;
        s1_next.vz = -u;
      end
      FACE_NEG_X: begin
        s1_next.vx = -$signed({2'b00, s_sat});
        s1_next.vy = -v;
        s1_next.vz = u;
      end
      FACE_POS_Y: begin
        s1_next.vx = u;
        s1_next.vy = $signed({2'b00, s_sat});
        s1_next.vz = v;
      end
      FACE_NEG_Y: begin
        s1_next.vx = u;
        s1_next.vy = -$signed({2'b00, s_sat});
        s1_next.vz = -v;
      end
      FACE_POS_Z: begin
        s1_next.vx = u;
        s1_next.vy = -v;
        s1_next.vz = $signed({2'b00, s_sat});
      end
      FACE_NEG_Z: begin
        s1_next.vx = -u;
        s1_next.vy = -v;
        s1_next.vz = -$signed({2'b00, s_sat});
      end
      default: begin
        s1_next.vx = '0;
        s1_next.vy = '0;
        s1_next.vz = '0;
      end
    endcase
  end

  always_comb begin
    mag[LANE_RED]   = s1.vx[VEC_W-1] ? MAG_W'(-s1.vx) : s1.vx[MAG_W-1:0];
    mag[LANE_GREEN] = s1.vy[VEC_W-1] ? MAG_W'(-s1.vy) : s1.vy[MAG_W-1:0];
    mag[LANE_BLUE]  = s1.vz[VEC_W-1] ? MAG_W'(-s1.vz) : s1.vz[MAG_W-1:0];
    mag[LANE_ALPHA] = (s1.vz > 0) ? {s1.vz[MAG_W-2:0], 1'b0} : '0;
    for (int i = 0; i < LANES; i++) begin
      s2_next.prod[i] = PROD_W'(mag[i] * s1.k);
    end
    for (int i = 0; i < COLORS; i++) begin
      s2_next.sq[i] = M_W'(mag[i+1] * mag[i+1]);
    end
    s2_next.neg = {s1.vz[VEC_W-1], s1.vy[VEC_W-1], s1.vx[VEC_W-1]};
  end

  always_comb begin
    m_sum = s2.sq[0] + s2.sq[1] + s2.sq[2];
    for (int i = 0; i < LANES; i++) begin
      s3_next.lane[i].rem = ACC_W'(s2.prod[i] * s2.prod[i]);
      s3_next.lane[i].p   = '0;
      s3_next.lane[i].n   = '0;
    end
    s3_next.mq    = ACC_W'({m_sum, {FRAC_W{1'b0}}});
    s3_next.neg   = s2.neg;
    s3_next.mzero = (m_sum == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) s1 <= s1_next;
    if (en2 && v1) s2 <= s2_next;
    if (en3 && v2) out_data <= s3_next;
  end
endmodule
`default_nettype wire

// ===== sv/ncm_cell.sv =====
`default_nettype none
module ncm_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [ncm_pkg::STEP_W-1:0]  step,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  ncm_pkg::root_t                   in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output ncm_pkg::root_t                   out_data
);
  import ncm_pkg::*;

  logic vld;
  root_t data_next;
  logic [LANES-1:0][ACC_W-1:0] trial;

  assign in_ready = !vld || out_ready;
  assign out_valid = vld;

  // try one result bit per lane: keep it if remainder covers the square growth
  always_comb begin
    data_next = in_data;
    for (int i = 0; i < LANES; i++) begin
      trial[i] = (in_data.lane[i].p << (step + STEP_W'(1)))
               + (in_data.mq << {step, 1'b0});
      if (in_data.lane[i].rem >= trial[i]) begin
        data_next.lane[i].rem = in_data.lane[i].rem - trial[i];
        data_next.lane[i].p   = in_data.lane[i].p + (in_data.mq << step);
        data_next.lane[i].n   = in_data.lane[i].n | (N_W'(1) << step);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) out_data <= data_next;
  end
endmodule
`default_nettype wire

// ===== sv/ncm_chk.sv =====
`default_nettype none
`include "normalization_cubemap_texel_unit_assert.svh"
module ncm_chk (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       req_ready,
  input wire logic                       rsp_valid,
  input wire logic                       rsp_ready,
  input wire logic [ncm_pkg::BYTE_W-1:0] rsp_alpha,
  input wire logic [ncm_pkg::BYTE_W-1:0] rsp_red,
  input wire logic [ncm_pkg::BYTE_W-1:0] rsp_green,
  input wire logic [ncm_pkg::BYTE_W-1:0] rsp_blue,
  input wire logic                       cfg_ready
);
  `NCM_ASSERT_NOW(a_cfg_ready, 1'b1, cfg_ready)
  `NCM_ASSERT_NOW(a_req_open, !rsp_valid || rsp_ready, req_ready)
  `NCM_ASSERT_NOW(a_empty_after_rst, $fell(rst), !rsp_valid)
  `NCM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_alpha, rsp_red, rsp_green, rsp_blue}))
endmodule

bind normalization_cubemap_texel_unit ncm_chk u_ncm_chk (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_alpha (rsp.alpha_byte),
  .rsp_red   (rsp.red_byte),
  .rsp_green (rsp.green_byte),
  .rsp_blue  (rsp.blue_byte),
  .cfg_ready (cfg.ready)
);
`default_nettype wire
